// ----- rtl/dlcmd_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual load cell median filter: shared package
// Widths, item types, configuration register map and reset values.
// ----------------------------------------------------------------------------
package dlcmd_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int LEVEL_BITS    = 18;
   localparam int LIMIT_BITS    = 8;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [LEVEL_BITS-1:0] BAND_LOW_RESET   = 18'd83500;
   localparam logic [LEVEL_BITS-1:0] BAND_HIGH_RESET  = 18'd84000;
   localparam logic [LIMIT_BITS-1:0] STEP_LIMIT_RESET = 8'd3;
   localparam logic [LIMIT_BITS-1:0] BIAS_LIMIT_RESET = 8'd2;
   localparam logic [LIMIT_BITS-1:0] HOLD_TICKS_RESET = 8'd250;
   localparam logic [LEVEL_BITS-1:0] BASELINE_RESET   = 18'd0;

   typedef enum logic [2:0] {
      REG_BAND_LOW   = 3'd0,
      REG_BAND_HIGH  = 3'd1,
      REG_STEP_LIMIT = 3'd2,
      REG_BIAS_LIMIT = 3'd3,
      REG_HOLD_TICKS = 3'd4,
      REG_BASELINE_A = 3'd5,
      REG_BASELINE_B = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_a;
      logic [SAMPLE_BITS-1:0] sample_b;
      logic                   check_enable;
   } req_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level_a;
      logic [LEVEL_BITS-1:0] level_b;
      logic                  window_full;
      logic [1:0]            disconnected;
   } rsp_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] band_low;
      logic [LEVEL_BITS-1:0] band_high;
      logic [LIMIT_BITS-1:0] step_limit;
      logic [LIMIT_BITS-1:0] bias_limit;
      logic [LIMIT_BITS-1:0] hold_ticks;
      logic [LEVEL_BITS-1:0] baseline_a;
      logic [LEVEL_BITS-1:0] baseline_b;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level_a;
      logic [LEVEL_BITS-1:0] level_b;
      logic                  check_enable;
   } scaled_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level_a;
      logic [LEVEL_BITS-1:0] level_b;
      logic                  window_full;
      logic                  check_enable;
   } median_type;

endpackage

// ----- rtl/dlcmd_csr.sv -----
// ----------------------------------------------------------------------------
// Dual load cell median filter: configuration registers
// APB-style register file holding the band, limits and tare baselines.
// ----------------------------------------------------------------------------
module dlcmd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dlcmd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dlcmd_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dlcmd_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready,
   output dlcmd_pkg::cfg_type                 cfg
);
   import dlcmd_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       write_en;
   logic [2:0] index;

   assign index      = csr_paddr[4:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_BAND_LOW:   cfg_in.band_low   = csr_pwdata[LEVEL_BITS-1:0];
            REG_BAND_HIGH:  cfg_in.band_high  = csr_pwdata[LEVEL_BITS-1:0];
            REG_STEP_LIMIT: cfg_in.step_limit = csr_pwdata[LIMIT_BITS-1:0];
            REG_BIAS_LIMIT: cfg_in.bias_limit = csr_pwdata[LIMIT_BITS-1:0];
            REG_HOLD_TICKS: cfg_in.hold_ticks = csr_pwdata[LIMIT_BITS-1:0];
            REG_BASELINE_A: cfg_in.baseline_a = csr_pwdata[LEVEL_BITS-1:0];
            REG_BASELINE_B: cfg_in.baseline_b = csr_pwdata[LEVEL_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_BAND_LOW:   csr_prdata = CSR_DATA_BITS'(cfg_ff.band_low);
         REG_BAND_HIGH:  csr_prdata = CSR_DATA_BITS'(cfg_ff.band_high);
         REG_STEP_LIMIT: csr_prdata = CSR_DATA_BITS'(cfg_ff.step_limit);
         REG_BIAS_LIMIT: csr_prdata = CSR_DATA_BITS'(cfg_ff.bias_limit);
         REG_HOLD_TICKS: csr_prdata = CSR_DATA_BITS'(cfg_ff.hold_ticks);
         REG_BASELINE_A: csr_prdata = CSR_DATA_BITS'(cfg_ff.baseline_a);
         REG_BASELINE_B: csr_prdata = CSR_DATA_BITS'(cfg_ff.baseline_b);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.band_low   <= BAND_LOW_RESET;
         cfg_ff.band_high  <= BAND_HIGH_RESET;
         cfg_ff.step_limit <= STEP_LIMIT_RESET;
         cfg_ff.bias_limit <= BIAS_LIMIT_RESET;
         cfg_ff.hold_ticks <= HOLD_TICKS_RESET;
         cfg_ff.baseline_a <= BASELINE_RESET;
         cfg_ff.baseline_b <= BASELINE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/dlcmd_scale.sv -----
// ----------------------------------------------------------------------------
// Dual load cell median filter: input register and scaling
// Registers the incoming item and divides both readings by 100.
// ----------------------------------------------------------------------------
module dlcmd_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dlcmd_pkg::req_type    req_data,
   output logic                  scaled_valid,
   input  logic                  scaled_ready,
   output dlcmd_pkg::scaled_type scaled_data
);
   import dlcmd_pkg::*;

   // Division by 100 is a shift by two and then a multiply by a rounded-up
   // reciprocal of 25, which is exact for every 22-bit operand.
   localparam int PRE_SHIFT    = 2;
   localparam int RECIP_SHIFT  = 27;
   localparam int RECIP_BITS   = 23;
   localparam int PRODUCT_BITS = SAMPLE_BITS - PRE_SHIFT + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_25 = RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd24) / 64'd25);

   function automatic logic [LEVEL_BITS-1:0] scale_level(input logic [SAMPLE_BITS-1:0] raw);
      logic [PRODUCT_BITS-1:0] product;
      product = PRODUCT_BITS'(raw[SAMPLE_BITS-1:PRE_SHIFT]) * PRODUCT_BITS'(RECIP_25);
      return product[RECIP_SHIFT +: LEVEL_BITS];
   endfunction

   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff, in_data_in;
   logic       sc_valid_ff, sc_valid_in;
   scaled_type sc_data_ff, sc_data_in;
   logic       sc_ready, in_ready, accept, advance;

   assign sc_ready     = !sc_valid_ff || scaled_ready;
   assign in_ready     = !in_valid_ff || sc_ready;
   assign accept       = req_valid && in_ready;
   assign advance      = in_valid_ff && sc_ready;
   assign req_stall    = !in_ready;
   assign scaled_valid = sc_valid_ff;
   assign scaled_data  = sc_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      sc_valid_in = sc_valid_ff;
      sc_data_in  = sc_data_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end
      if (sc_valid_ff && scaled_ready) begin
         sc_valid_in = 1'b0;
      end
      if (advance) begin
         sc_valid_in             = 1'b1;
         sc_data_in.level_a      = scale_level(in_data_ff.sample_a);
         sc_data_in.level_b      = scale_level(in_data_ff.sample_b);
         sc_data_in.check_enable = in_data_ff.check_enable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         sc_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         sc_valid_ff <= sc_valid_in;
      end
      in_data_ff <= in_data_in;
      sc_data_ff <= sc_data_in;
   end

endmodule

// ----- rtl/dlcmd_median.sv -----
// ----------------------------------------------------------------------------
// Dual load cell median filter: sample windows and median network
// Keeps a ring of the latest levels per channel and registers their medians.
// ----------------------------------------------------------------------------
module dlcmd_median #(
   parameter int WINDOW = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  scaled_valid,
   output logic                  scaled_ready,
   input  dlcmd_pkg::scaled_type scaled_data,
   output logic                  median_valid,
   input  logic                  median_ready,
   output dlcmd_pkg::median_type median_data
);
   import dlcmd_pkg::*;

   localparam int SLOT_BITS = $clog2(WINDOW);
   localparam int FILL_BITS = $clog2(WINDOW + 1);
   localparam int RANK_BITS = $clog2(WINDOW);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT  = SLOT_BITS'(WINDOW - 1);
   localparam logic [FILL_BITS-1:0] FULL_COUNT = FILL_BITS'(WINDOW);
   localparam logic [RANK_BITS-1:0] MID_RANK   = RANK_BITS'(WINDOW / 2);

   // Each entry's rank is the number of entries that sort ahead of it, ties
   // broken by position, so exactly one entry holds the middle rank.
   function automatic logic [LEVEL_BITS-1:0] pick_median(
      input logic [WINDOW-1:0][LEVEL_BITS-1:0] ring
   );
      logic [RANK_BITS-1:0]  rank;
      logic [LEVEL_BITS-1:0] result;
      result = '0;
      for (int i = 0; i < WINDOW; i++) begin
         rank = '0;
         for (int j = 0; j < WINDOW; j++) begin
            if ((ring[j] < ring[i]) || ((ring[j] == ring[i]) && (j < i))) begin
               rank = rank + RANK_BITS'(1);
            end
         end
         if (rank == MID_RANK) begin
            result = ring[i];
         end
      end
      return result;
   endfunction

   logic [WINDOW-1:0][LEVEL_BITS-1:0] window_a_ff, window_a_in;
   logic [WINDOW-1:0][LEVEL_BITS-1:0] window_b_ff, window_b_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic                 win_valid_ff, win_valid_in;
   logic                 win_full_ff, win_full_in;
   logic                 win_check_ff, win_check_in;
   logic                 out_valid_ff, out_valid_in;
   median_type           out_ff, out_in;
   logic                 out_ready, win_ready, write_en, advance;

   assign out_ready    = !out_valid_ff || median_ready;
   assign win_ready    = !win_valid_ff || out_ready;
   assign write_en     = scaled_valid && win_ready;
   assign advance      = win_valid_ff && out_ready;
   assign scaled_ready = win_ready;
   assign median_valid = out_valid_ff;
   assign median_data  = out_ff;

   always_comb begin
      window_a_in  = window_a_ff;
      window_b_in  = window_b_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      win_valid_in = win_valid_ff;
      win_full_in  = win_full_ff;
      win_check_in = win_check_ff;
      if (advance) begin
         win_valid_in = 1'b0;
      end
      if (write_en) begin
         window_a_in[slot_ff] = scaled_data.level_a;
         window_b_in[slot_ff] = scaled_data.level_b;
         slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + SLOT_BITS'(1);
         if (fill_ff != FULL_COUNT) begin
            fill_in = fill_ff + FILL_BITS'(1);
         end
         win_valid_in = 1'b1;
         win_full_in  = (fill_in == FULL_COUNT);
         win_check_in = scaled_data.check_enable;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_valid_ff && median_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in        = 1'b1;
         out_in.level_a      = pick_median(window_a_ff);
         out_in.level_b      = pick_median(window_b_ff);
         out_in.window_full  = win_full_ff;
         out_in.check_enable = win_check_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         fill_ff      <= '0;
         win_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         win_valid_ff <= win_valid_in;
         out_valid_ff <= out_valid_in;
      end
      window_a_ff  <= window_a_in;
      window_b_ff  <= window_b_in;
      win_full_ff  <= win_full_in;
      win_check_ff <= win_check_in;
      out_ff       <= out_in;
   end

`ifndef SYNTHESIS
   a_full_needs_fill: assert property (@(posedge clock) disable iff (reset)
      (win_valid_ff && win_full_ff) |-> (fill_ff == FULL_COUNT))
      else $error("window reported full before every slot was written");
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      write_en |=> (slot_ff <= LAST_SLOT))
      else $error("write slot left the ring");
`endif

endmodule

// ----- rtl/dlcmd_detect.sv -----
// ----------------------------------------------------------------------------
// Dual load cell median filter: disconnect detector and result register
// Tests each level for a frozen or zero reading, counts how long that holds
// and raises the per-channel flag once the count passes the hold limit.
// ----------------------------------------------------------------------------
module dlcmd_detect (
   input  logic                  clock,
   input  logic                  reset,
   input  dlcmd_pkg::cfg_type    cfg,
   input  logic                  median_valid,
   output logic                  median_ready,
   input  dlcmd_pkg::median_type median_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dlcmd_pkg::rsp_type    rsp_data
);
   import dlcmd_pkg::*;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level_a;
      logic [LEVEL_BITS-1:0] level_b;
      logic                  window_full;
      logic                  check_enable;
      logic                  frozen_a;
      logic                  frozen_b;
   } check_type;

   function automatic logic is_frozen(
      input logic [LEVEL_BITS-1:0] level,
      input logic [LEVEL_BITS-1:0] previous,
      input logic [LEVEL_BITS-1:0] baseline,
      input cfg_type               limits
   );
      logic [LEVEL_BITS-1:0] step;
      logic [LEVEL_BITS-1:0] bias;
      step = (level > previous) ? level - previous : previous - level;
      bias = (level > baseline) ? level - baseline : baseline - level;
      return (level == '0) ||
             ((level >= limits.band_low) && (level < limits.band_high) &&
              (step < LEVEL_BITS'(limits.step_limit)) &&
              (bias <= LEVEL_BITS'(limits.bias_limit)));
   endfunction

   function automatic logic [LIMIT_BITS-1:0] bump(
      input logic [LIMIT_BITS-1:0] count,
      input logic                  cond
   );
      logic [LIMIT_BITS-1:0] result;
      result = '0;
      if (cond) begin
         result = (count == '1) ? count : count + LIMIT_BITS'(1);
      end
      return result;
   endfunction

   logic [LEVEL_BITS-1:0] cur_a_ff, cur_a_in;
   logic [LEVEL_BITS-1:0] cur_b_ff, cur_b_in;
   logic                  chk_valid_ff, chk_valid_in;
   check_type             chk_ff, chk_in;
   logic [LIMIT_BITS-1:0] cnt_a_ff, cnt_a_in;
   logic [LIMIT_BITS-1:0] cnt_b_ff, cnt_b_in;
   logic [1:0]            flag_ff, flag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  out_ready, chk_ready, chk_load, out_load, evaluate;

   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign chk_ready    = !chk_valid_ff || out_ready;
   assign chk_load     = median_valid && chk_ready;
   assign out_load     = chk_valid_ff && out_ready;
   assign evaluate     = out_load && chk_ff.window_full && chk_ff.check_enable;
   assign median_ready = chk_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_comb begin
      cur_a_in     = cur_a_ff;
      cur_b_in     = cur_b_ff;
      chk_valid_in = chk_valid_ff;
      chk_in       = chk_ff;
      if (out_load) begin
         chk_valid_in = 1'b0;
      end
      if (chk_load) begin
         chk_valid_in        = 1'b1;
         chk_in.window_full  = median_data.window_full;
         chk_in.check_enable = median_data.check_enable;
         chk_in.frozen_a     = is_frozen(median_data.level_a, cur_a_ff, cfg.baseline_a, cfg);
         chk_in.frozen_b     = is_frozen(median_data.level_b, cur_b_ff, cfg.baseline_b, cfg);
         if (median_data.window_full) begin
            cur_a_in = median_data.level_a;
            cur_b_in = median_data.level_b;
         end else begin
            cur_a_in = '0;
            cur_b_in = '0;
         end
         chk_in.level_a = cur_a_in;
         chk_in.level_b = cur_b_in;
      end
   end

   always_comb begin
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (evaluate) begin
         cnt_a_in = bump(cnt_a_ff, chk_ff.frozen_a);
         cnt_b_in = bump(cnt_b_ff, chk_ff.frozen_b);
         flag_in  = {cnt_b_in > cfg.hold_ticks, cnt_a_in > cfg.hold_ticks};
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in        = 1'b1;
         rsp_in.level_a      = chk_ff.level_a;
         rsp_in.level_b      = chk_ff.level_b;
         rsp_in.window_full  = chk_ff.window_full;
         rsp_in.disconnected = flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_a_ff     <= '0;
         cur_b_ff     <= '0;
         chk_valid_ff <= 1'b0;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         flag_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_a_ff     <= cur_a_in;
         cur_b_ff     <= cur_b_in;
         chk_valid_ff <= chk_valid_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_ff <= chk_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_flag_hold: assert property (@(posedge clock) disable iff (reset)
      !evaluate |=> $stable(flag_ff))
      else $error("disconnect flags changed without an evaluation");
   a_count_kept: assert property (@(posedge clock) disable iff (reset)
      (evaluate && chk_ff.frozen_a) |=> (cnt_a_ff != '0))
      else $error("frozen counter of channel a lost its count");
   a_warmup_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.window_full) |->
         ((rsp_ff.level_a == '0) && (rsp_ff.level_b == '0)))
      else $error("nonzero level reported while the window fills");
`endif

endmodule

// ----- rtl/dual_load_cell_median_disconnect.sv -----
// ----------------------------------------------------------------------------
// Dual load cell sliding median filter with disconnect detection
// Each item carries one raw reading per channel and gives exactly one result
// item. Readings are divided by 100 and kept in a ring of WINDOW levels per
// channel; the level is the median of that ring, and it reads 0 until WINDOW
// items have arrived. When checking is enabled and the window is full, a level
// that sits frozen in the configured band near its baseline, or reads zero,
// advances a saturating counter, and the channel's disconnect flag is set
// while that counter is above hold_ticks. The block takes one item every clock
// cycle while the result port is not stalled. The item passes six registers:
// the input register, the reciprocal multiply, the window write, the median
// network, the frozen test and the counter update. The stages close up around
// a stalled result, so up to six items are held in flight.
// ----------------------------------------------------------------------------
module dual_load_cell_median_disconnect #(
   parameter int WINDOW = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dlcmd_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dlcmd_pkg::rsp_type                  rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dlcmd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dlcmd_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dlcmd_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                csr_pready
);
   import dlcmd_pkg::*;

   cfg_type    cfg;
   logic       scaled_valid, scaled_ready;
   scaled_type scaled_data;
   logic       median_valid, median_ready;
   median_type median_data;

   dlcmd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dlcmd_scale u_scale (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .scaled_valid (scaled_valid),
      .scaled_ready (scaled_ready),
      .scaled_data  (scaled_data)
   );

   dlcmd_median #(
      .WINDOW (WINDOW)
   ) u_median (
      .clock        (clock),
      .reset        (reset),
      .scaled_valid (scaled_valid),
      .scaled_ready (scaled_ready),
      .scaled_data  (scaled_data),
      .median_valid (median_valid),
      .median_ready (median_ready),
      .median_data  (median_data)
   );

   dlcmd_detect u_detect (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .median_valid (median_valid),
      .median_ready (median_ready),
      .median_data  (median_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
